@@ hdl/tmq_pkg.sv @@
package tmq_pkg;

	localparam int CAPACITY    = 16;
	localparam int CLIENT_BITS = 8;

	// client handle as stored: the port carries 8 bits at most
	localparam int CLIENT_W = (CLIENT_BITS < 8) ? CLIENT_BITS : 8;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OCC_W    = 5;

	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_NEXT = 1'b1;

	// seconds in the low bits, so {hours, minutes, seconds} is the sort key
	typedef struct packed {
		logic [CLIENT_W-1:0] client;
		logic [4:0]          hours;
		logic [5:0]          minutes;
		logic [5:0]          seconds;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// tags the store read word that arrives this cycle
	typedef struct packed {
		logic             valid;
		logic             first;
		logic [IDX_W-1:0] idx;
	} scan_ctl_t;

endpackage

@@ hdl/tmq_ram.sv @@
module tmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/tmq_minscan.sv @@
module tmq_minscan (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tmq_pkg::scan_ctl_t        ctl,
	input  tmq_pkg::entry_t           rd_entry,
	output logic [tmq_pkg::IDX_W-1:0] best_idx,
	output tmq_pkg::entry_t           best_entry
);
	import tmq_pkg::*;

	entry_t           best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             earlier;

	// strict less-than: on a tie the earlier slot stays
	assign earlier = {rd_entry.hours, rd_entry.minutes, rd_entry.seconds}
		< {best_q.hours, best_q.minutes, best_q.seconds};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_idx_q <= '0;
		end else if (ctl.valid && (ctl.first || earlier)) begin
			best_idx_q <= ctl.idx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.valid && (ctl.first || earlier)) begin
			best_q <= rd_entry;
		end
	end

	assign best_idx   = best_idx_q;
	assign best_entry = best_q;

endmodule

@@ hdl/timed_event_min_queue_top.sv @@
// channel | dir | tdata (low bit up)                              | tuser
// s_*     | in  | client_id 8, event_hours 5, event_minutes 6,    | action
//         |     | event_seconds 6, zero pad to 32                 |
// m_*     | out | out_client 8, out_hours 5, out_minutes 6,       | ok
//         |     | out_seconds 6, occupancy 5, zero pad to 32      |
//
// Add, or next on an empty store: result valid from the output step, ready again that same cycle.
// Next otherwise: the store is scanned, drained, set up and compacted from the removed slot on, then
// a final step and the output step give the result, ready again that same cycle: one store read per
// cycle through a single key comparator, then one read/write per cycle to close the gap.
// s_tready is high only between items; a result waits in the output register and the next
// word is accepted meanwhile, but that word stalls in its output step until m_tready.
// Reset clears the event count; store contents need no clearing.
module timed_event_min_queue_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // client_id, event_hours, event_minutes, event_seconds
	input  logic        s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // out_client, out_hours, out_minutes, out_seconds, occupancy
	output logic        m_tuser   // ok
);
	import tmq_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_SETUP = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;

	logic             scan_s1;
	logic             first_s1;
	logic [IDX_W-1:0] scan_idx_s1;
	logic             shift_s1;
	logic [IDX_W-1:0] wr_idx_s1;

	logic             res_ok_q;
	entry_t           res_entry_q;
	logic [CNT_W-1:0] res_cnt_q;

	logic             acc;
	logic             full;
	logic             add_wr;
	logic             last_scan;
	logic             more_shift;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	entry_t           in_entry;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_entry;
	scan_ctl_t        scan_ctl;
	logic [IDX_W-1:0] best_idx;
	entry_t           best_entry;

	assign s_tready = (state_q == S_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign add_wr   = acc && (s_tuser == ACT_ADD) && !full;

	assign in_entry.client  = s_tdata[CLIENT_W-1:0];
	assign in_entry.hours   = s_tdata[12:8];
	assign in_entry.minutes = s_tdata[18:13];
	assign in_entry.seconds = s_tdata[24:19];

	assign last_scan  = (CNT_W'(idx_q) == CNT_W'(count_q - CNT_W'(1)));
	assign more_shift = (CNT_W'(idx_q) + CNT_W'(1)) < count_q;

	// a shift write lands in the cycle after its read
	assign wr_en   = add_wr || shift_s1;
	assign wr_addr = shift_s1 ? wr_idx_s1 : IDX_W'(count_q);
	assign wr_data = shift_s1 ? rd_entry : in_entry;
	assign rd_addr = (state_q == S_SHIFT) ? IDX_W'(idx_q + IDX_W'(1)) : idx_q;

	assign scan_ctl.valid = scan_s1;
	assign scan_ctl.first = first_s1;
	assign scan_ctl.idx   = scan_idx_s1;

	tmq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_entry)
	);

	tmq_minscan u_minscan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.rd_entry   (rd_entry),
		.best_idx   (best_idx),
		.best_entry (best_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			scan_s1     <= 1'b0;
			first_s1    <= 1'b0;
			scan_idx_s1 <= '0;
			shift_s1    <= 1'b0;
			wr_idx_s1   <= '0;
			res_ok_q    <= 1'b0;
			res_cnt_q   <= '0;
			m_tvalid    <= 1'b0;
		end else begin
			scan_s1  <= (state_q == S_SCAN);
			first_s1 <= (state_q == S_SCAN) && (idx_q == '0);
			shift_s1 <= (state_q == S_SHIFT) && more_shift;
			if (state_q == S_OUT && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (s_tuser == ACT_ADD) begin
							res_ok_q  <= !full;
							res_cnt_q <= full ? count_q : CNT_W'(count_q + CNT_W'(1));
							if (!full) begin
								count_q <= CNT_W'(count_q + CNT_W'(1));
							end
							state_q <= S_OUT;
						end else if (count_q == '0) begin
							res_ok_q  <= 1'b0;
							res_cnt_q <= '0;
							state_q   <= S_OUT;
						end else begin
							idx_q   <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					scan_idx_s1 <= idx_q;
					idx_q       <= IDX_W'(idx_q + IDX_W'(1));
					if (last_scan) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					idx_q   <= best_idx;
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (more_shift) begin
						wr_idx_s1 <= idx_q;
						idx_q     <= IDX_W'(idx_q + IDX_W'(1));
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					count_q   <= CNT_W'(count_q - CNT_W'(1));
					res_ok_q  <= 1'b1;
					res_cnt_q <= CNT_W'(count_q - CNT_W'(1));
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload: zero unless a next item found an event
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && acc) begin
			res_entry_q <= '0;
		end else if (state_q == S_FIN) begin
			res_entry_q <= best_entry;
		end
		if (state_q == S_OUT && (!m_tvalid || m_tready)) begin
			m_tuser <= res_ok_q;
			m_tdata <= {2'b00, OCC_W'(res_cnt_q), res_entry_q.seconds, res_entry_q.minutes,
				res_entry_q.hours, 8'(res_entry_q.client)};
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("event count above capacity");

	a_full_add_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tuser == ACT_ADD && full) |=> $stable(count_q))
		else $error("rejected add changed the count");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		shift_s1 |-> (CNT_W'(wr_idx_s1) + CNT_W'(1)) < count_q)
		else $error("compaction write beyond stored events");

	a_fin_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> (count_q != '0))
		else $error("removal from an empty store");

	a_scan_then_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> $past(state_q) == S_SCAN)
		else $error("drain without a scan");

endmodule
